>>> rtl/core/lseu_pkg.sv
// Shared types, codes and constants for the logic and shift execute unit.
`default_nettype none

package lseu_pkg;

  // Operation codes.
  localparam logic [3:0] OP_AND   = 4'd0;
  localparam logic [3:0] OP_EOR   = 4'd1;
  localparam logic [3:0] OP_ORA   = 4'd2;
  localparam logic [3:0] OP_ASL   = 4'd3;
  localparam logic [3:0] OP_LSR   = 4'd4;
  localparam logic [3:0] OP_ROL   = 4'd5;
  localparam logic [3:0] OP_ROR   = 4'd6;
  localparam logic [3:0] OP_WRITE = 4'd7;
  localparam logic [3:0] OP_READ  = 4'd8;
  localparam logic [3:0] OP_SET   = 4'd9;

  // Addressing mode codes.
  localparam logic [2:0] MODE_IMM  = 3'd0;
  localparam logic [2:0] MODE_ZP   = 3'd1;
  localparam logic [2:0] MODE_ZPX  = 3'd2;
  localparam logic [2:0] MODE_ABS  = 3'd3;
  localparam logic [2:0] MODE_ABSX = 3'd4;
  localparam logic [2:0] MODE_ABSY = 3'd5;
  localparam logic [2:0] MODE_INDX = 3'd6;
  localparam logic [2:0] MODE_INDY = 3'd7;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Status byte bit positions.
  localparam int FLAG_N_BIT = 7;
  localparam int FLAG_Z_BIT = 1;
  localparam int FLAG_C_BIT = 0;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR_LO,
    ST_PTR_HI,
    ST_PTR_ADR,
    ST_RD,
    ST_EXEC
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic ptr_lo;
    logic ptr_hi;
    logic ptr_adr;
    logic exec;
  } dp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic go_ptr;
    logic go_read;
    logic item_read;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lseu_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module lseu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One access per cycle; read data appears the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/lseu_ctrl.sv
// Sequencer for the execute unit: steps each request through its memory accesses.
`default_nettype none

module lseu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire lseu_pkg::dp_stat_t stat,
  output logic                   busy,
  output lseu_pkg::dp_cmd_t      cmd
);

  import lseu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (stat.go_ptr) begin
            state_nxt = ST_PTR_LO;
          end else if (stat.go_read) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_PTR_LO:  state_nxt = ST_PTR_HI;
      ST_PTR_HI:  state_nxt = ST_PTR_ADR;
      ST_PTR_ADR: state_nxt = stat.item_read ? ST_RD : ST_EXEC;
      ST_RD:      state_nxt = ST_EXEC;
      ST_EXEC:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs; the operand read uses the default memory address.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_PTR_LO:  cmd.ptr_lo  = 1'b1;
      ST_PTR_HI:  cmd.ptr_hi  = 1'b1;
      ST_PTR_ADR: cmd.ptr_adr = 1'b1;
      ST_RD:      busy        = 1'b1;
      ST_EXEC:    cmd.exec    = 1'b1;
      default:    busy        = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/lseu_dp.sv
// Datapath: address generation, memory, accumulator, status byte and result registers.
`default_nettype none

module lseu_dp #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lseu_pkg::dp_cmd_t  cmd,
  output lseu_pkg::dp_stat_t      stat,
  input  wire logic [3:0]         in_operation,
  input  wire logic [2:0]         in_mode,
  input  wire logic [7:0]         in_operand_low,
  input  wire logic [7:0]         in_operand_high,
  input  wire logic [7:0]         in_index_x,
  input  wire logic [7:0]         in_index_y,
  input  wire logic [7:0]         in_data,
  output logic                    out_valid,
  output logic [7:0]              out_acc_out,
  output logic [7:0]              out_flags_out,
  output logic [7:0]              out_result_byte,
  output logic [15:0]             out_effective_address,
  output logic                    out_page_crossed,
  output logic                    out_status
);

  import lseu_pkg::*;

  localparam int          DEPTH   = 1 << ADDR_BITS;
  localparam logic [15:0] EA_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

  // Request registers.
  logic [3:0]  op_r;
  logic [2:0]  mode_r;
  logic [7:0]  lo_r;
  logic [7:0]  y_r;
  logic [7:0]  dat_r;
  logic [7:0]  ptr_r;
  logic [7:0]  ptrlo_r;
  logic        bad_r;
  logic        need_read_r;
  logic [15:0] ea_r;
  logic        cross_r;

  // Architectural state.
  logic [7:0] acc_r;
  logic [7:0] flags_r;
  logic [7:0] acc_nxt;
  logic [7:0] flags_nxt;

  // Result registers.
  logic        valid_r;
  logic [7:0]  res_r;
  logic [7:0]  res_nxt;
  logic [15:0] ea_out_r;
  logic        cross_out_r;
  logic        status_r;

  // Memory port.
  logic [ADDR_BITS-1:0] ram_addr;
  logic                 ram_we;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;

  // Decode of an incoming request.
  logic        bad_in;
  logic        mem_in;
  logic        read_in;
  logic [7:0]  zpx_in;
  logic [15:0] base_in;
  logic [7:0]  idx_in;
  logic [16:0] sum_in;
  logic [15:0] ea_in;
  logic        cross_in;

  always_comb begin
    bad_in = 1'b0;
    if (in_operation > OP_SET) begin
      bad_in = 1'b1;
    end else if (in_operation inside {[OP_ASL:OP_ROR]} &&
                 in_mode inside {MODE_ABSY, MODE_INDX, MODE_INDY}) begin
      bad_in = 1'b1;
    end else if ((in_operation == OP_WRITE || in_operation == OP_READ) &&
                 in_mode == MODE_IMM) begin
      bad_in = 1'b1;
    end
    mem_in  = !bad_in && (in_operation != OP_SET) && (in_mode != MODE_IMM);
    read_in = mem_in && (in_operation != OP_WRITE);
  end

  // Direct effective address and page crossing for the non-pointer modes.
  always_comb begin
    zpx_in   = in_operand_low + in_index_x;
    base_in  = {in_operand_high, in_operand_low};
    idx_in   = (in_mode == MODE_ABSX) ? in_index_x : in_index_y;
    sum_in   = {1'b0, base_in} + {9'd0, idx_in};
    ea_in    = 16'd0;
    cross_in = 1'b0;
    case (in_mode)
      MODE_ZP:  ea_in = {8'd0, in_operand_low};
      MODE_ZPX: ea_in = {8'd0, zpx_in};
      MODE_ABS: ea_in = base_in;
      MODE_ABSX, MODE_ABSY: begin
        ea_in    = sum_in[15:0];
        cross_in = (sum_in[15:8] != base_in[15:8]);
      end
      default: begin
        ea_in    = 16'd0;
        cross_in = 1'b0;
      end
    endcase
    if (!mem_in) begin
      ea_in    = 16'd0;
      cross_in = 1'b0;
    end
  end

  assign stat.go_ptr    = mem_in && (in_mode == MODE_INDX || in_mode == MODE_INDY);
  assign stat.go_read   = read_in;
  assign stat.item_read = need_read_r;

  // Pointer-based address, formed once both pointer bytes are in.
  logic [15:0] pbase;
  logic [15:0] psum;

  assign pbase = {ram_rdata, ptrlo_r};
  assign psum  = pbase + {8'd0, y_r};

  // Request capture and address registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_operation;
      mode_r      <= in_mode;
      lo_r        <= in_operand_low;
      y_r         <= in_index_y;
      dat_r       <= in_data;
      bad_r       <= bad_in;
      need_read_r <= read_in;
      ptr_r       <= (in_mode == MODE_INDX) ? zpx_in : in_operand_low;
      ea_r        <= ea_in;
      cross_r     <= cross_in;
    end
    if (cmd.ptr_hi) begin
      ptrlo_r <= ram_rdata;
    end
    if (cmd.ptr_adr) begin
      if (mode_r == MODE_INDY) begin
        ea_r    <= psum;
        cross_r <= (psum[15:8] != pbase[15:8]);
      end else begin
        ea_r    <= pbase;
        cross_r <= 1'b0;
      end
    end
  end

  // Memory address select: pointer bytes wrap within zero page.
  logic [7:0] ptr_inc;

  assign ptr_inc = ptr_r + 8'd1;

  always_comb begin
    ram_addr = ea_r[ADDR_BITS-1:0];
    if (cmd.ptr_lo) begin
      ram_addr = ADDR_BITS'(ptr_r);
    end else if (cmd.ptr_hi) begin
      ram_addr = ADDR_BITS'(ptr_inc);
    end
  end

  // Operation execute.
  logic [7:0] v_log;
  logic [7:0] v_sh;
  logic [7:0] nv;
  logic       cout;

  always_comb begin
    v_log = (mode_r == MODE_IMM) ? lo_r : ram_rdata;
    v_sh  = (mode_r == MODE_IMM) ? acc_r : ram_rdata;
    nv    = 8'd0;
    cout  = 1'b0;
    case (op_r)
      OP_ASL: begin
        nv   = {v_sh[6:0], 1'b0};
        cout = v_sh[7];
      end
      OP_LSR: begin
        nv   = {1'b0, v_sh[7:1]};
        cout = v_sh[0];
      end
      OP_ROL: begin
        nv   = {v_sh[6:0], flags_r[FLAG_C_BIT]};
        cout = v_sh[7];
      end
      OP_ROR: begin
        nv   = {flags_r[FLAG_C_BIT], v_sh[7:1]};
        cout = v_sh[0];
      end
      default: begin
        nv   = 8'd0;
        cout = 1'b0;
      end
    endcase
  end

  always_comb begin
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    res_nxt   = 8'd0;
    ram_we    = 1'b0;
    ram_wdata = dat_r;
    if (!bad_r) begin
      case (op_r)
        OP_AND, OP_EOR, OP_ORA: begin
          if (op_r == OP_AND) begin
            acc_nxt = acc_r & v_log;
          end else if (op_r == OP_EOR) begin
            acc_nxt = acc_r ^ v_log;
          end else begin
            acc_nxt = acc_r | v_log;
          end
          flags_nxt[FLAG_N_BIT] = acc_nxt[7];
          flags_nxt[FLAG_Z_BIT] = (acc_nxt == 8'd0);
        end
        OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
          flags_nxt[FLAG_N_BIT] = nv[7];
          flags_nxt[FLAG_Z_BIT] = (nv == 8'd0);
          flags_nxt[FLAG_C_BIT] = cout;
          if (mode_r == MODE_IMM) begin
            acc_nxt = nv;
          end else begin
            ram_we    = cmd.exec;
            ram_wdata = nv;
            res_nxt   = nv;
          end
        end
        OP_WRITE: begin
          ram_we    = cmd.exec;
          ram_wdata = dat_r;
          res_nxt   = dat_r;
        end
        OP_READ: res_nxt = ram_rdata;
        OP_SET: begin
          acc_nxt   = dat_r;
          flags_nxt = lo_r;
        end
        default: res_nxt = 8'd0;
      endcase
    end
  end

  // Accumulator, status byte and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'd0;
      flags_r <= 8'd0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.exec;
      if (cmd.exec) begin
        acc_r   <= acc_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  // Result fields; crossing is only reported for logic and read operations.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r       <= res_nxt;
      ea_out_r    <= ea_r & EA_MASK;
      cross_out_r <= cross_r &&
                     (op_r == OP_AND || op_r == OP_EOR || op_r == OP_ORA ||
                      op_r == OP_READ);
      status_r    <= bad_r ? STATUS_BAD : STATUS_OK;
    end
  end

  lseu_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid             = valid_r;
  assign out_acc_out           = acc_r;
  assign out_flags_out         = flags_r;
  assign out_result_byte       = res_r;
  assign out_effective_address = ea_out_r;
  assign out_page_crossed      = cross_out_r;
  assign out_status            = status_r;

endmodule

`default_nettype wire

>>> rtl/core/logic_shift_execute_unit_6502.sv
// Top level of the 6502 logic and shift execute unit.
`default_nettype none

// A request is taken when start is high and busy is low; its result is shown
// for one cycle with out_valid, which the receiver must take at once. A request
// that reads no memory (immediate, accumulator, set, an invalid request, or a
// write at a direct address) goes straight to its execute step; a read or shift
// at a direct address first reads its operand, a write through a zero-page
// pointer first reads both pointer bytes and forms the pointer address, and a
// read through one then also reads its operand. These steps follow from the
// single memory port, which does one access per cycle with registered read
// data, and every request ends with an execute step that also does any write.
// The unit takes no new request until it is through with the last. The memory
// powers up undefined and has no clearing pass. busy drops in the cycle the
// result is shown, so a new request can be taken alongside it.
module logic_shift_execute_unit_6502 #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_operation,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_operand_low,
  input  wire logic [7:0]  in_operand_high,
  input  wire logic [7:0]  in_index_x,
  input  wire logic [7:0]  in_index_y,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  output logic [7:0]       out_acc_out,
  output logic [7:0]       out_flags_out,
  output logic [7:0]       out_result_byte,
  output logic [15:0]      out_effective_address,
  output logic             out_page_crossed,
  output logic             out_status
);

  import lseu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  lseu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath with the data memory.
  lseu_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_operation          (in_operation),
    .in_mode               (in_mode),
    .in_operand_low        (in_operand_low),
    .in_operand_high       (in_operand_high),
    .in_index_x            (in_index_x),
    .in_index_y            (in_index_y),
    .in_data               (in_data),
    .out_valid             (out_valid),
    .out_acc_out           (out_acc_out),
    .out_flags_out         (out_flags_out),
    .out_result_byte       (out_result_byte),
    .out_effective_address (out_effective_address),
    .out_page_crossed      (out_page_crossed),
    .out_status            (out_status)
  );

endmodule

`default_nettype wire

>>> rtl/core/lseu_checker.sv
// Port-level checks for the execute unit and their binding to the top level.
`default_nettype none

module lseu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [7:0]  out_result_byte,
  input wire logic [15:0] out_effective_address,
  input wire logic        out_page_crossed,
  input wire logic        out_status
);

  import lseu_pkg::*;

  // An accepted request keeps the unit busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a request");

  // A result only follows a busy cycle and comes out as busy drops.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without preceding work");

  // One strobe per request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // An invalid request reports no address, byte or page crossing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_BAD) |->
      (out_result_byte == 8'd0 && out_effective_address == 16'd0 && !out_page_crossed))
    else $error("invalid request reported payload");

endmodule

bind logic_shift_execute_unit_6502 lseu_checker u_lseu_checker (.*);

`default_nettype wire
